/* rtl/core/c8080_pkg.sv */
// Shared types and constants for the 8080 subset execute core.
package c8080_pkg;
    localparam int unsigned MemWords = 65536;
    localparam int unsigned AddrW = $clog2(MemWords);
    localparam logic [15:0] RomLimitRst = 16'h2000;
    localparam logic [16:0] RamLimitRst = 17'h04000;

    localparam logic [1:0] ST_EXEC = 2'd0;
    localparam logic [1:0] ST_REFUSED = 2'd1;
    localparam logic [1:0] ST_HALT = 2'd2;
    localparam logic [1:0] ST_LOADED = 2'd3;

    localparam logic [1:0] ADDR_ROM_LIMIT = 2'd0;
    localparam logic [1:0] ADDR_RAM_LIMIT = 2'd1;

    typedef struct packed {
        logic [0:0] mode;
        logic [15:0] load_address;
        logic [7:0] load_byte;
    } t_req;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] opcode_seen;
        logic [15:0] next_pc;
        logic [7:0] accumulator;
        logic [7:0] flag_byte;
        logic [15:0] pair_bc;
        logic [15:0] pair_de;
        logic [15:0] pair_hl;
        logic [15:0] stack_pointer;
    } t_rsp;

    // memory access kinds issued by the controller
    typedef enum logic [2:0] {
        MA_NONE, MA_OP, MA_B1, MA_B2, MA_DATA, MA_DATA2, MA_LOAD
    } t_macc;

    typedef struct packed {
        t_macc acc;
        logic  exec_wr;
        logic  wr2;
        logic  finish;
        logic  start;
    } t_cmd;

    typedef struct packed {
        logic       halted;
        logic       is_load;
        logic       unknown;
        logic       need_wr2;
    } t_sts;

    function automatic logic parity_even(input logic [7:0] v);
        return ~^v;
    endfunction
endpackage

/* rtl/core/c8080_if.sv */
// Valid/ready channel interface carrying one payload.
interface c8080_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/c8080_ctrl.sv */
// Sequencer that steps one request through its memory accesses.
module c8080_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_out_free,
    input  c8080_pkg::t_sts  i_sts,
    output c8080_pkg::t_cmd  o_cmd
);
    import c8080_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE = 9'b0_0000_0001,
        S_OP   = 9'b0_0000_0010,
        S_B1   = 9'b0_0000_0100,
        S_B2   = 9'b0_0000_1000,
        S_RD   = 9'b0_0001_0000,
        S_RD2  = 9'b0_0010_0000,
        S_WR   = 9'b0_0100_0000,
        S_WR2  = 9'b0_1000_0000,
        S_DONE = 9'b1_0000_0000
    } t_state;

    t_state r_state, n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_cmd.acc = MA_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state = S_OP;
                end
            end
            S_OP: begin
                if (i_sts.is_load) begin
                    o_cmd.acc = MA_LOAD;
                    n_state = S_DONE;
                end else if (i_sts.halted) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.acc = MA_OP;
                    n_state = S_B1;
                end
            end
            S_B1: begin
                if (i_sts.unknown) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.acc = MA_B1;
                    n_state = S_B2;
                end
            end
            S_B2: begin
                o_cmd.acc = MA_B2;
                n_state = S_RD;
            end
            S_RD: begin
                o_cmd.acc = MA_DATA;
                n_state = S_RD2;
            end
            S_RD2: begin
                o_cmd.acc = MA_DATA2;
                n_state = S_WR;
            end
            S_WR: begin
                o_cmd.exec_wr = 1'b1;
                n_state = i_sts.need_wr2 ? S_WR2 : S_DONE;
            end
            S_WR2: begin
                o_cmd.wr2 = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end
endmodule

/* rtl/core/c8080_dp.sv */
// Register file, flags, memory and instruction execution datapath.
module c8080_dp #(
    parameter int unsigned MEM_WORDS = c8080_pkg::MemWords
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  c8080_pkg::t_cmd  i_cmd,
    input  c8080_pkg::t_req  i_req,
    input  logic [15:0]      i_rom_limit,
    input  logic [16:0]      i_ram_limit,
    output c8080_pkg::t_sts  o_sts,
    output c8080_pkg::t_rsp  o_rsp
);
    import c8080_pkg::*;

    localparam int unsigned AW = $clog2(MEM_WORDS);

    logic [7:0] r_mem [MEM_WORDS];
    logic [7:0] r_rdata;
    // byte from the first data read
    logic [7:0] r_rd1;

    logic [7:0] r_b, r_c, r_d, r_e, r_h, r_l, r_a;
    logic [15:0] r_pc, r_sp;
    logic r_cy, r_p, r_z, r_s, r_halted;
    t_req r_req;
    logic [7:0] r_op, r_b1, r_b2;
    logic r_refused;
    logic [1:0] r_status;

    // memory read address
    logic [15:0] mem_raddr;
    logic [15:0] word;
    logic [15:0] hl, bc, de;
    logic [1:0] pr;
    logic [2:0] rsel;
    logic [3:0] low;
    logic [7:0] op;

    assign op = r_rdata; // valid in cycle after MA_OP
    assign word = {r_b2, r_b1};
    assign hl = {r_h, r_l};
    assign bc = {r_b, r_c};
    assign de = {r_d, r_e};
    assign pr = r_op[5:4];
    assign rsel = r_op[5:3];
    assign low = r_op[3:0];

    // store address/data chosen per opcode
    logic [15:0] wr_addr, rd_addr;
    logic [7:0] wr_data;
    logic is_store, is_store2, in_range;
    logic [7:0] mval;

    always_comb begin
        is_store = 1'b0;
        is_store2 = 1'b0;
        wr_addr = hl;
        rd_addr = hl;
        wr_data = r_a;
        mval = r_rd1 + ((r_op[0]) ? 8'hff : 8'h01);
        if (r_op <= 8'h38) begin
            case (low)
                4'h2: begin
                    is_store = 1'b1;
                    if (pr == 2'd0) wr_addr = bc;
                    else if (pr == 2'd1) wr_addr = de;
                    else if (pr == 2'd2) begin
                        wr_addr = word;
                        wr_data = r_l;
                        is_store2 = 1'b1;
                    end else wr_addr = word;
                end
                4'h4, 4'h5, 4'hc, 4'hd: begin
                    if (rsel == 3'd6 && r_op != 8'h25) begin
                        is_store = 1'b1;
                        wr_data = mval;
                    end
                end
                4'h6, 4'he: begin
                    if (rsel == 3'd6) begin
                        is_store = 1'b1;
                        wr_data = r_b1;
                    end
                end
                4'ha: begin
                    if (pr == 2'd0) rd_addr = bc;
                    else if (pr == 2'd1) rd_addr = de;
                    // high operand byte is still on the read port here
                    else rd_addr = {r_rdata, r_b1};
                end
                default: ;
            endcase
        end
    end

    logic [15:0] st_addr;
    assign st_addr = i_cmd.wr2 ? (word + 16'd1) : wr_addr;
    assign in_range = ({1'b0, st_addr} >= {1'b0, i_rom_limit}) &&
                      ({1'b0, st_addr} < i_ram_limit);

    always_comb begin
        case (i_cmd.acc)
            MA_OP:    mem_raddr = r_pc;
            MA_B1:    mem_raddr = r_pc + 16'd1;
            MA_B2:    mem_raddr = r_pc + 16'd2;
            MA_DATA:  mem_raddr = rd_addr;
            MA_DATA2: mem_raddr = word + 16'd1;
            default:  mem_raddr = r_req.load_address;
        endcase
    end

    logic mem_we;
    logic [15:0] mem_waddr;
    logic [7:0] mem_wdata;
    always_comb begin
        mem_we = 1'b0;
        mem_waddr = st_addr;
        mem_wdata = i_cmd.wr2 ? r_h : wr_data;
        if (i_cmd.acc == MA_LOAD) begin
            mem_we = 1'b1;
            mem_waddr = r_req.load_address;
            mem_wdata = r_req.load_byte;
        end else if ((i_cmd.exec_wr && is_store) || i_cmd.wr2) begin
            mem_we = in_range;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_waddr[AW-1:0]] <= mem_wdata;
        r_rdata <= r_mem[mem_raddr[AW-1:0]];
    end

    assign o_sts.halted = r_halted;
    assign o_sts.is_load = ~r_req.mode[0];
    assign o_sts.unknown = (op <= 8'h38) && (op != 8'h00) && (op[2:0] == 3'd0);
    assign o_sts.need_wr2 = is_store2;

    // phase tracking: remember which access produced r_rdata
    t_macc r_last;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_last <= MA_NONE;
        else r_last <= i_cmd.acc;
    end

    logic [16:0] dad;
    logic [15:0] pv, pinc;
    always_comb begin
        case (pr)
            2'd0: pv = bc;
            2'd1: pv = de;
            2'd2: pv = hl;
            default: pv = r_sp;
        endcase
        dad = {1'b0, hl} + {1'b0, pv};
        pinc = r_op[3] ? (pv - 16'd1) : (pv + 16'd1);
    end

    logic [7:0] rv, rinc, da1, dsum8;
    logic [8:0] dsum;
    always_comb begin
        case (rsel)
            3'd0: rv = r_b;
            3'd1: rv = r_c;
            3'd2: rv = r_d;
            3'd3: rv = r_e;
            3'd4: rv = r_h;
            3'd5: rv = r_l;
            default: rv = r_a;
        endcase
        rinc = rv + (r_op[0] ? 8'hff : 8'h01);
        da1 = (r_a[3:0] > 4'd9) ? (r_a + 8'd6) : r_a;
        dsum = {1'b0, da1} + 9'h060;
        dsum8 = dsum[7:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            {r_b, r_c, r_d, r_e, r_h, r_l, r_a} <= '0;
            r_pc <= '0;
            r_sp <= '0;
            {r_cy, r_p, r_z, r_s} <= '0;
            r_halted <= 1'b0;
            r_status <= ST_EXEC;
            r_op <= '0;
            r_refused <= 1'b0;
        end else begin
            if (i_cmd.start) begin
                r_refused <= 1'b0;
                r_op <= 8'h00;
                r_status <= i_req.mode[0] ? (r_halted ? ST_HALT : ST_EXEC) : ST_LOADED;
            end
            if (r_last == MA_OP && r_status == ST_EXEC) begin
                r_op <= op;
                if (o_sts.unknown) begin
                    r_halted <= 1'b1;
                    r_status <= ST_HALT;
                end
            end
            if (r_last == MA_B1) r_b1 <= r_rdata;
            if (r_last == MA_B2) r_b2 <= r_rdata;
            if (r_last == MA_DATA) r_rd1 <= r_rdata;
            if (((i_cmd.exec_wr && is_store) || i_cmd.wr2) && !in_range)
                r_refused <= 1'b1;
            // architectural update in the write phase
            if (i_cmd.exec_wr) begin
                r_pc <= r_pc + 16'd1;
                if (r_op <= 8'h38) begin
                    case (low)
                        4'h1: begin
                            r_pc <= r_pc + 16'd3;
                            case (pr)
                                2'd0: {r_b, r_c} <= word;
                                2'd1: {r_d, r_e} <= word;
                                2'd2: {r_h, r_l} <= word;
                                default: r_sp <= word;
                            endcase
                        end
                        4'h2: if (pr[1]) r_pc <= r_pc + 16'd3;
                        4'h3, 4'hb: begin
                            case (pr)
                                2'd0: {r_b, r_c} <= pinc;
                                2'd1: {r_d, r_e} <= pinc;
                                2'd2: {r_h, r_l} <= pinc;
                                default: r_sp <= pinc;
                            endcase
                        end
                        4'h4, 4'h5, 4'hc, 4'hd: begin
                            if (r_op != 8'h25) begin
                                if (rsel == 3'd6) begin
                                    r_z <= (mval == 8'h00);
                                    r_s <= mval[7];
                                    r_p <= parity_even(mval);
                                end else begin
                                    r_z <= (rinc == 8'h00);
                                    r_s <= rinc[7];
                                    r_p <= parity_even(rinc);
                                    case (rsel)
                                        3'd0: r_b <= rinc;
                                        3'd1: r_c <= rinc;
                                        3'd2: r_d <= rinc;
                                        3'd3: r_e <= rinc;
                                        3'd4: r_h <= rinc;
                                        3'd5: r_l <= rinc;
                                        default: r_a <= rinc;
                                    endcase
                                end
                            end
                        end
                        4'h6, 4'he: begin
                            r_pc <= r_pc + 16'd2;
                            case (rsel)
                                3'd0: r_b <= r_b1;
                                3'd1: r_c <= r_b1;
                                3'd2: r_d <= r_b1;
                                3'd3: r_e <= r_b1;
                                3'd4: r_h <= r_b1;
                                3'd5: r_l <= r_b1;
                                3'd7: r_a <= r_b1;
                                default: ;
                            endcase
                        end
                        4'h9: begin
                            {r_h, r_l} <= dad[15:0];
                            r_cy <= dad[16];
                        end
                        4'ha: begin
                            if (pr[1]) begin
                                r_pc <= r_pc + 16'd3;
                                r_l <= r_rd1;
                                r_h <= r_rdata;
                            end else r_a <= r_rd1;
                        end
                        4'h7: begin
                            case (pr)
                                2'd0: begin
                                    r_a <= {r_a[6:0], r_a[7]};
                                    r_cy <= r_a[7];
                                end
                                2'd1: begin
                                    r_a <= {r_a[6:0], r_cy};
                                    r_cy <= r_a[7];
                                end
                                2'd2: begin
                                    if (da1[7:4] > 4'h9) begin
                                        r_a <= dsum8;
                                        r_cy <= dsum[8];
                                        r_z <= (dsum8 == 8'h00);
                                        r_s <= dsum8[7];
                                        r_p <= parity_even(dsum8);
                                    end else r_a <= da1;
                                end
                                default: r_cy <= 1'b1;
                            endcase
                        end
                        4'hf: begin
                            case (pr)
                                2'd0: begin
                                    r_a <= {r_a[0], r_a[7:1]};
                                    r_cy <= r_a[0];
                                end
                                2'd1: begin
                                    r_a <= {r_cy, r_a[7:1]};
                                    r_cy <= r_a[0];
                                end
                                2'd2: r_a <= ~r_a;
                                default: ;
                            endcase
                        end
                        default: ;
                    endcase
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) r_req <= i_req;
    end

    always_comb begin
        o_rsp.status = (r_status == ST_EXEC && r_refused) ? ST_REFUSED : r_status;
        o_rsp.opcode_seen = r_op;
        o_rsp.next_pc = r_pc;
        o_rsp.accumulator = r_a;
        o_rsp.flag_byte = {r_s, r_z, 1'b0, 1'b0, 1'b0, r_p, 1'b0, r_cy};
        o_rsp.pair_bc = bc;
        o_rsp.pair_de = de;
        o_rsp.pair_hl = hl;
        o_rsp.stack_pointer = r_sp;
    end
endmodule

/* rtl/core/cpu8080_subset_execute_core.sv */
// Top level of the 8080 subset execute core with APB register port.
//  channel  | dir | payload
//  req      | in  | mode, load_address, load_byte
//  rsp      | out | status, opcode_seen, next_pc, registers, flags
//  apb      | in  | rom_limit (0x0), ram_limit (0x4)
// Requests are taken in IDLE; a load or halted step runs OP, DONE, unknown opcode
// OP, B1, DONE, an execute step OP, B1, B2, RD, RD2, WR, DONE, and SHLD adds WR2.
// The single memory read port carries opcode, two operand bytes and two data reads.
// Reset clears registers, flags, pc and halt; limits return to 0x2000 and 0x4000.
// A stalled result holds in the output register; one more request is taken and
// waits in its last state until the register frees.
module cpu8080_subset_execute_core #(
    parameter int unsigned MEM_WORDS = c8080_pkg::MemWords
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    c8080_if.sink       i_req,
    c8080_if.source     o_rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import c8080_pkg::*;

    t_cmd cmd;
    t_sts sts;
    t_rsp rsp;
    logic [15:0] r_rom_limit;
    logic [16:0] r_ram_limit;
    logic r_out_valid;
    t_rsp r_out;
    logic out_free;

    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rom_limit <= RomLimitRst;
            r_ram_limit <= RamLimitRst;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == ADDR_RAM_LIMIT[0]) r_ram_limit <= pwdata[16:0];
            else r_rom_limit <= pwdata[15:0];
        end
    end
    always_comb begin
        case (paddr[2])
            1'b0: prdata = {16'd0, r_rom_limit};
            default: prdata = {15'd0, r_ram_limit};
        endcase
    end

    assign out_free = ~r_out_valid | o_rsp.ready;

    c8080_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_req.valid),
        .o_in_ready(i_req.ready), .i_out_free(out_free), .i_sts(sts), .o_cmd(cmd)
    );

    c8080_dp #(.MEM_WORDS(MEM_WORDS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .i_req(i_req.data),
        .i_rom_limit(r_rom_limit), .i_ram_limit(r_ram_limit),
        .o_sts(sts), .o_rsp(rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_valid <= 1'b0;
        else if (cmd.finish) r_out_valid <= 1'b1;
        else if (o_rsp.ready) r_out_valid <= 1'b0;
    end
    always_ff @(posedge i_clk) begin
        if (cmd.finish) r_out <= rsp;
    end
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data = r_out;
endmodule
